/* sv/afts_pkg.sv */
`timescale 1ns / 1ps

package afts_pkg;

  // detection phase, one-hot
  typedef enum logic [2:0] {
    PH_DETECT = 3'b001,
    PH_HEADER = 3'b010,
    PH_SKIP   = 3'b100
  } phase_t;

  // candidate flag bits
  localparam int unsigned F_ID3  = 0;
  localparam int unsigned F_FLAC = 1;
  localparam int unsigned F_MP3  = 2;
  localparam int unsigned F_WAVE = 3;

  // result codes
  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_FLAC = 2'd1;
  localparam logic [1:0] TYPE_MP3  = 2'd2;
  localparam logic [1:0] TYPE_WAVE = 2'd3;

  localparam logic [4:0] ID3V2_HEADER_LAST = 5'd9;
  localparam logic [4:0] SIZE_FIRST        = 5'd6;
  localparam logic [4:0] ID3_LAST          = 5'd2;
  localparam logic [4:0] SIG_LAST          = 5'd3;
  localparam logic [4:0] WAVE_LAST         = 5'd21;
  localparam logic [7:0] SYNC_BYTE         = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE       = 4'hF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] file_type;
  } result_t;

  // "ID3" at offsets 0 to 2
  function automatic logic id3_hit(input logic [1:0] p, input logic [7:0] b);
    logic hit;
    begin
      case (p)
        2'd0:    hit = (b == 8'h49);
        2'd1:    hit = (b == 8'h44);
        2'd2:    hit = (b == 8'h33);
        default: hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

  // "fLaC" at offsets 0 to 3
  function automatic logic flac_hit(input logic [1:0] p, input logic [7:0] b);
    logic hit;
    begin
      case (p)
        2'd0:    hit = (b == 8'h66);
        2'd1:    hit = (b == 8'h4C);
        2'd2:    hit = (b == 8'h61);
        default: hit = (b == 8'h43);
      endcase
      return hit;
    end
  endfunction

  // RIFF / WAVE / fmt / PCM tag, unchecked offsets always match
  function automatic logic wave_hit(input logic [4:0] p, input logic [7:0] b);
    logic hit;
    begin
      case (p)
        5'd0:    hit = (b == 8'h52);
        5'd1:    hit = (b == 8'h49);
        5'd2:    hit = (b == 8'h46);
        5'd3:    hit = (b == 8'h46);
        5'd8:    hit = (b == 8'h57);
        5'd9:    hit = (b == 8'h41);
        5'd10:   hit = (b == 8'h56);
        5'd11:   hit = (b == 8'h45);
        5'd12:   hit = (b == 8'h66);
        5'd13:   hit = (b == 8'h6D);
        5'd14:   hit = (b == 8'h74);
        5'd15:   hit = (b == 8'h20);
        5'd20:   hit = (b == 8'h01);
        5'd21:   hit = (b == 8'h00);
        default: hit = 1'b1;
      endcase
      return hit;
    end
  endfunction

endpackage

/* sv/afts_in_reg.sv */
`timescale 1ns / 1ps

module afts_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  afts_pkg::item_t in_item,
  input  logic            adv,
  output logic            s1_valid,
  output afts_pkg::item_t s1_item
);

  logic            valid_r, valid_nxt;
  afts_pkg::item_t item_r;

  // stage holds one item, refilled whenever it drains
  assign in_ready  = !valid_r || adv;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* sv/afts_core.sv */
`timescale 1ns / 1ps

module afts_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  afts_pkg::item_t   item,
  output afts_pkg::result_t res
);

  afts_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]       pos_r, pos_nxt;
  logic [27:0]      skip_r, skip_nxt;
  logic [3:0]       flags_r, flags_nxt;
  logic             decided_r, decided_nxt;

  logic [7:0]  b;
  logic        eof;
  logic [27:0] skip_hdr;
  logic [27:0] skip_dec;
  logic [3:0]  f;
  logic        det_emit;
  logic [1:0]  det_type;

  assign b        = item.data_byte;
  assign eof      = item.end_of_file;
  assign skip_hdr = (pos_r >= afts_pkg::SIZE_FIRST) ? {skip_r[20:0], b[6:0]} : skip_r;
  assign skip_dec = skip_r - 28'd1;

  // candidate checks at the current offset
  always_comb begin
    f = flags_r;
    if (!(pos_r <= afts_pkg::ID3_LAST && afts_pkg::id3_hit(pos_r[1:0], b))) begin
      f[afts_pkg::F_ID3] = 1'b0;
    end
    if (!(pos_r <= afts_pkg::SIG_LAST && afts_pkg::flac_hit(pos_r[1:0], b))) begin
      f[afts_pkg::F_FLAC] = 1'b0;
    end
    if (pos_r > afts_pkg::SIG_LAST ||
        (pos_r == 5'd0 && b != afts_pkg::SYNC_BYTE) ||
        (pos_r == 5'd1 && b[7:4] != afts_pkg::SYNC_NIBBLE)) begin
      f[afts_pkg::F_MP3] = 1'b0;
    end
    if (pos_r > afts_pkg::WAVE_LAST || !afts_pkg::wave_hit(pos_r, b)) begin
      f[afts_pkg::F_WAVE] = 1'b0;
    end
  end

  // next state for one byte
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    skip_nxt    = skip_r;
    flags_nxt   = flags_r;
    decided_nxt = decided_r;
    det_emit    = 1'b0;
    det_type    = afts_pkg::TYPE_NONE;
    if (!decided_r) begin
      case (phase_r)
        afts_pkg::PH_HEADER: begin
          skip_nxt = skip_hdr;
          if (pos_r >= afts_pkg::ID3V2_HEADER_LAST) begin
            pos_nxt   = 5'd0;
            flags_nxt = 4'b1110;
            phase_nxt = (skip_hdr == 28'd0) ? afts_pkg::PH_DETECT : afts_pkg::PH_SKIP;
          end else begin
            pos_nxt = pos_r + 5'd1;
          end
        end
        afts_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 28'd0) begin
            phase_nxt = afts_pkg::PH_DETECT;
            pos_nxt   = 5'd0;
          end
        end
        afts_pkg::PH_DETECT: begin
          flags_nxt = f;
          if (f == 4'd0) begin
            det_emit = 1'b1;
          end else if (pos_r == afts_pkg::ID3_LAST && f[afts_pkg::F_ID3]) begin
            phase_nxt = afts_pkg::PH_HEADER;
            pos_nxt   = 5'd3;
            skip_nxt  = 28'd0;
          end else if (pos_r == afts_pkg::SIG_LAST && f[afts_pkg::F_FLAC]) begin
            det_emit = 1'b1;
            det_type = afts_pkg::TYPE_FLAC;
          end else if (pos_r == afts_pkg::SIG_LAST && f[afts_pkg::F_MP3]) begin
            det_emit = 1'b1;
            det_type = afts_pkg::TYPE_MP3;
          end else if (pos_r == afts_pkg::WAVE_LAST && f[afts_pkg::F_WAVE]) begin
            det_emit = 1'b1;
            det_type = afts_pkg::TYPE_WAVE;
          end else begin
            pos_nxt = pos_r + 5'd1;
          end
        end
        default: begin
          phase_nxt = afts_pkg::PH_DETECT;
        end
      endcase
      if (det_emit) begin
        decided_nxt = 1'b1;
      end
    end
    // end of file rearms everything
    if (eof) begin
      phase_nxt   = afts_pkg::PH_DETECT;
      pos_nxt     = 5'd0;
      skip_nxt    = 28'd0;
      flags_nxt   = 4'b1111;
      decided_nxt = 1'b0;
    end
  end

  // one result per file: the decision, or none at end of file
  assign res.emit      = !decided_r && (det_emit || eof);
  assign res.file_type = det_type;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= afts_pkg::PH_DETECT;
      pos_r     <= 5'd0;
      skip_r    <= 28'd0;
      flags_r   <= 4'b1111;
      decided_r <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      skip_r    <= skip_nxt;
      flags_r   <= flags_nxt;
      decided_r <= decided_nxt;
    end
  end

endmodule

/* sv/afts_out_reg.sv */
`timescale 1ns / 1ps

module afts_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  afts_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_type
);

  logic       valid_r, valid_nxt;
  logic [1:0] type_r;

  // slot is free when empty or being taken this cycle
  assign free      = !valid_r || out_ready;
  assign valid_nxt = free ? (fire && res.emit) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && fire && res.emit) begin
      type_r <= res.file_type;
    end
  end

  assign out_valid = valid_r;
  assign out_type  = type_r;

endmodule

/* sv/audio_file_type_sniffer.sv */
`timescale 1ns / 1ps

// channel | ports                      | contents
// in      | in_tvalid/in_tready        | tdata[7:0] data_byte, tlast end_of_file
// out     | out_tvalid/out_tready      | tdata[1:0] file_type, tdata[7:2] zero
//
// one byte per clock while the output is not stalled; each byte's result is registered
// the detect step (compare plus position and size counters) sits between an
// input register and an output register
// rst_n is synchronous and returns the block to the start-of-file state
// a held result stalls the input stage only when the output register stays full

module audio_file_type_sniffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] file_type, [7:2] zero
);

  afts_pkg::item_t   in_item;
  afts_pkg::item_t   s1_item;
  afts_pkg::result_t res;
  logic              s1_valid;
  logic              out_free;
  logic              fire;
  logic [1:0]        out_type;

  assign in_item.data_byte   = in_tdata;
  assign in_item.end_of_file = in_tlast;
  assign fire                = s1_valid && out_free;

  // input register
  afts_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .adv      (out_free),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // detection state and step logic
  afts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item),
    .res   (res)
  );

  // result register
  afts_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_type  (out_type)
  );

  assign out_tdata = {6'd0, out_type};

endmodule

/* sv/afts_checker.sv */
`timescale 1ns / 1ps

module afts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // empty output register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // draining output frees the input side
  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0)
    else $error("nonzero padding in output item");

endmodule

bind audio_file_type_sniffer afts_checker u_afts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
